[rtl/ordered_list_engine_top_assert.svh]
// Assertion macros used by the checker of the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define OLE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ole_pkg.sv]
// Shared types, codes and sizes of the ordered list engine.
package ole_pkg;

	// Default list depth
	localparam int DEPTH_DEF = 16;

	// Field widths
	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int CNT_OUT_W = 5;
	localparam int OUT_W    = 40;

	// Operation codes
	localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
	localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd1;
	localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;
		logic shift_en;
	} cell_ctrl_t;

endpackage

[rtl/ordered_list_engine_top.sv]
// Ordered list engine: a row of cells and an idle/execute sequencer with an output register.
// The output register loads when the sequencer commits, once any waiting result has gone.
// A new item is taken only after the previous one has committed; the compare of every cell is
// registered on acceptance; the hit chain with the shift or load is committed in the execute state.
// The sequencer holds the next input while a finished result still waits downstream.
// Reset clears the entry count, sequencer and output valid; cell contents stay undefined.
module ordered_list_engine_top #(
	parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ole_pkg::VAL_W-1:0]     s_tdata,  // value
	input  logic [ole_pkg::OP_W-1:0]      s_tuser,  // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ole_pkg::OUT_W-1:0]     m_tdata   // status, entry_count, is_empty, head_value
);
	import ole_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// Sequencer codes
	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic             state_q;
	logic [CW-1:0]    count_q;
	logic [OP_W-1:0]  op_s1;
	logic [VAL_W-1:0] value_s1;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic             in_xfer;
	logic             commit;
	cell_ctrl_t       ctrl;
	logic             force_first;
	logic             found;
	logic             append_ok;
	logic [CW-1:0]    count_next;
	logic [STATUS_W-1:0] status_next;
	logic [VAL_W-1:0] head_next;
	logic [CW+CNT_OUT_W-1:0] count_ext;

	logic [VAL_W-1:0] data_w [DEPTH];
	logic [DEPTH:0]   hit_w;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign commit   = (state_q == S_EXEC) && (!m_tvalid_q || m_tready);

	// Broadcast controls
	assign force_first   = (op_s1 == OP_DEL_FIRST);
	assign hit_w[0]      = force_first;
	assign found         = hit_w[DEPTH];
	assign append_ok     = (op_s1 == OP_APPEND) && (count_q != DEPTH_C);
	assign ctrl.cmp_en   = in_xfer;
	assign ctrl.shift_en = commit && (count_q != '0) &&
		(((op_s1 == OP_DEL_VALUE) && found) || force_first);

	// Row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] nxt;
		if (i < DEPTH - 1) begin : g_mid
			assign nxt = data_w[i+1];
		end else begin : g_last
			assign nxt = data_w[i];
		end
		ole_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.occupied   (CW'(i) < count_q),
			.cmp_value  (s_tdata),
			.load_en    (commit && append_ok && (count_q == CW'(i))),
			.load_value (value_s1),
			.nxt_data   (nxt),
			.hit_in     (hit_w[i]),
			.hit_out    (hit_w[i+1]),
			.data       (data_w[i])
		);
	end

	// Work out the new count and status
	always_comb begin
		count_next  = count_q;
		status_next = ST_OK;
		case (op_s1)
			OP_APPEND: begin
				if (count_q == DEPTH_C) status_next = ST_FULL;
				else count_next = count_q + ONE_C;
			end
			OP_DEL_VALUE: begin
				if (count_q == '0) status_next = ST_EMPTY;
				else if (found) count_next = count_q - ONE_C;
				else status_next = ST_NOT_FOUND;
			end
			OP_DEL_FIRST, OP_DEL_LAST: begin
				if (count_q == '0) status_next = ST_EMPTY;
				else count_next = count_q - ONE_C;
			end
			OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	// Head after the operation
	always_comb begin
		if (count_next == '0) head_next = '0;
		else if (ctrl.shift_en && hit_w[1]) head_next = data_w[1];
		else if (append_ok && (count_q == '0)) head_next = value_s1;
		else head_next = data_w[0];
	end

	assign count_ext = {{CNT_OUT_W{1'b0}}, count_next};

	// Sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			if (in_xfer) state_q <= S_EXEC;
			else if (commit) state_q <= S_IDLE;
			if (commit) count_q <= count_next;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1    <= s_tuser;
			value_s1 <= s_tdata;
		end
	end

	// Output register: load on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {head_next, (count_next == '0), count_ext[CNT_OUT_W-1:0], status_next};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/ole_cell.sv]
// One list cell: holds an entry, compares it, and takes its neighbor's entry on a shift or loads an appended value.
module ole_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ole_pkg::cell_ctrl_t         ctrl,
	input  logic                        occupied,
	input  logic [ole_pkg::VAL_W-1:0]   cmp_value,
	input  logic                        load_en,
	input  logic [ole_pkg::VAL_W-1:0]   load_value,
	input  logic [ole_pkg::VAL_W-1:0]   nxt_data,
	input  logic                        hit_in,
	output logic                        hit_out,
	output logic [ole_pkg::VAL_W-1:0]   data
);
	import ole_pkg::*;

	logic [VAL_W-1:0] data_q;
	logic             match_q;

	// Register the compare of this entry against the incoming value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			match_q <= occupied && (data_q == cmp_value);
		end
	end

	// Pass the hit down the chain: this cell and all after it close the gap
	assign hit_out = hit_in | match_q;

	// Take the neighbor's entry on a shift, or load an appended value
	always_ff @(posedge clk) begin
		if (ctrl.shift_en && hit_out) begin
			data_q <= nxt_data;
		end else if (load_en) begin
			data_q <= load_value;
		end
	end

	assign data = data_q;

endmodule

[rtl/ole_checker.sv]
// Port-level checks of the ordered list engine, bound to the top level.
`include "ordered_list_engine_top_assert.svh"

module ole_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [ole_pkg::OUT_W-1:0] m_tdata
);
	import ole_pkg::*;

	// A stalled result holds
	`OLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// An accepted item blocks the input once the sequencer has moved to execute
	`OLE_ASSERT_NEXT(a_busy_after_xfer, s_tvalid && s_tready, !s_tready, "input taken during execution")

	// An empty list shows a zero head
	`OLE_ASSERT_SAME(a_empty_head, m_tvalid && m_tdata[7], m_tdata[39:8] == '0, "empty list with nonzero head")

	// A delete on an empty list leaves it empty
	`OLE_ASSERT_SAME(a_empty_status, m_tvalid && (m_tdata[1:0] == ST_EMPTY), m_tdata[7], "empty status on a filled list")

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (.*);

[bench/testbench.sv]
// Self-checking stream testbench for the ordered list engine.
`timescale 1ns / 100ps

module testbench;
	import ole_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int STIM_ITEMS = 1750;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 300;

	// One report word as it leaves the block, status in the lowest bits
	typedef struct packed {
		logic [VAL_W-1:0]     head_value;
		logic                 is_empty;
		logic [CNT_OUT_W-1:0] entry_count;
		logic [STATUS_W-1:0]  status;
	} list_report_t;

	// Shadow of the list contents and the queue of reports it predicts
	class list_shadow;
		logic [VAL_W-1:0] cells [LIST_DEPTH];
		int unsigned      fill;
		list_report_t     expected_reports [$];
		int unsigned      fail_count;
		int unsigned      checked_count;

		function new();
			fill = 0;
			fail_count = 0;
			checked_count = 0;
		endfunction

		// Close the gap left by the entry at pos
		function void remove_at(int unsigned pos);
			for (int unsigned i = pos; i + 1 < fill; i++)
				cells[i] = cells[i + 1];
			fill--;
		endfunction

		// Apply one accepted operation and queue its report
		function void record_op(logic [OP_W-1:0] op, logic [VAL_W-1:0] value);
			logic [STATUS_W-1:0] st;
			int                  hit;
			list_report_t        rep;
			st = ST_OK;
			case (op)
				OP_APPEND: begin
					if (fill >= LIST_DEPTH) begin
						st = ST_FULL;
					end else begin
						cells[fill] = value;
						fill++;
					end
				end
				OP_DEL_VALUE: begin
					if (fill == 0) begin
						st = ST_EMPTY;
					end else begin
						st = ST_NOT_FOUND;
						hit = -1;
						for (int i = 0; i < fill; i++)
							if (hit < 0 && cells[i] == value)
								hit = i;
						if (hit >= 0) begin
							remove_at(hit);
							st = ST_OK;
						end
					end
				end
				OP_DEL_FIRST: begin
					if (fill == 0)
						st = ST_EMPTY;
					else
						remove_at(0);
				end
				OP_DEL_LAST: begin
					if (fill == 0)
						st = ST_EMPTY;
					else
						fill--;
				end
				OP_CLEAR: begin
					fill = 0;
				end
				default: begin
				end
			endcase
			rep.status = st;
			rep.entry_count = fill[CNT_OUT_W-1:0];
			rep.is_empty = (fill == 0);
			rep.head_value = (fill == 0) ? '0 : cells[0];
			expected_reports.push_back(rep);
		endfunction

		// Compare one delivered report with the oldest prediction
		function void check_report(logic [OUT_W-1:0] word);
			list_report_t got, want;
			got = list_report_t'(word);
			checked_count++;
			if (expected_reports.size() == 0) begin
				$error("unexpected report %h", word);
				fail_count++;
				return;
			end
			want = expected_reports.pop_front();
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				fail_count++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count expected %0d actual %0d",
					want.entry_count, got.entry_count);
				fail_count++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty expected %0d actual %0d", want.is_empty, got.is_empty);
				fail_count++;
			end
			if (got.head_value !== want.head_value) begin
				$error("head_value expected %h actual %h", want.head_value, got.head_value);
				fail_count++;
			end
		endfunction

		function int unsigned pending();
			return expected_reports.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [VAL_W-1:0]   s_tdata = '0;   // value
	logic [OP_W-1:0]    s_tuser = '0;   // op
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;        // status, entry_count, is_empty, head_value

	list_shadow         shadow = new();
	logic [VAL_W-1:0]   value_pool [6];

	ordered_list_engine_top #(
		.DEPTH(LIST_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Offer one operation and hold it until the transfer
	task automatic send_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
		s_tuser <= op;
		s_tdata <= value;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		shadow.record_op(op, value);
	endtask

	// Drop valid for a number of cycles
	task automatic idle_sender(input int unsigned cycles);
		if (cycles != 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Pick a value: mostly from the pool or the live list so deletes hit
	function automatic logic [VAL_W-1:0] pick_value(input logic [OP_W-1:0] op);
		int unsigned roll;
		roll = $urandom_range(99);
		if (op == OP_DEL_VALUE && shadow.fill != 0 && roll < 70)
			return shadow.cells[$urandom_range(shadow.fill - 1)];
		if (roll < 85)
			return value_pool[$urandom_range(5)];
		return $urandom;
	endfunction

	// Pick an operation weighted toward growing or shrinking the list
	function automatic logic [OP_W-1:0] pick_op(input bit growing);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return OP_CLEAR + OP_W'($urandom_range(3, 1));
		if (roll < 5)
			return OP_CLEAR;
		if (growing) begin
			if (roll < 70) return OP_APPEND;
			if (roll < 86) return OP_DEL_VALUE;
			if (roll < 93) return OP_DEL_FIRST;
			return OP_DEL_LAST;
		end
		if (roll < 30) return OP_APPEND;
		if (roll < 65) return OP_DEL_VALUE;
		if (roll < 82) return OP_DEL_FIRST;
		return OP_DEL_LAST;
	endfunction

	// Sender: reset, directed cases, random bursts, drain and verdict
	initial begin : sender
		int unsigned      issued;
		int unsigned      burst;
		bit               growing;
		logic [OP_W-1:0]  op;
		value_pool[0] = '0;
		value_pool[1] = 32'h8000_0000;
		value_pool[2] = 32'h7fff_ffff;
		value_pool[3] = 32'hffff_ffff;
		value_pool[4] = $urandom;
		value_pool[5] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Deletes and clear on an empty list, then the unused codes
		send_op(OP_DEL_VALUE, 32'h0000_0001);
		send_op(OP_DEL_FIRST, '0);
		send_op(OP_DEL_LAST, '0);
		send_op(OP_CLEAR, '0);
		for (int k = 1; k <= 3; k++)
			send_op(OP_CLEAR + OP_W'(k), 32'hffff_ffff);
		// Extremes, a duplicate, a missing value, a head hit, first-of-duplicates
		send_op(OP_APPEND, 32'h8000_0000);
		send_op(OP_APPEND, 32'h7fff_ffff);
		send_op(OP_APPEND, 32'hffff_ffff);
		send_op(OP_APPEND, '0);
		send_op(OP_APPEND, 32'h7fff_ffff);
		send_op(OP_DEL_VALUE, 32'h1234_5678);
		send_op(OP_DEL_VALUE, 32'h8000_0000);
		send_op(OP_DEL_VALUE, 32'h7fff_ffff);
		send_op(OP_DEL_LAST, '0);
		send_op(OP_DEL_FIRST, '0);
		// Delete the last remaining entry by value
		send_op(OP_DEL_VALUE, '0);
		// Fill to capacity, overflow once, then clear a full list
		for (int k = 0; k < LIST_DEPTH; k++)
			send_op(OP_APPEND, $urandom);
		send_op(OP_APPEND, 32'h5555_aaaa);
		send_op(OP_CLEAR, '0);
		idle_sender(3);

		// Random bursts with random gaps
		issued = 0;
		growing = 1'b1;
		while (issued < STIM_ITEMS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				if (growing && shadow.fill == LIST_DEPTH && $urandom_range(3) == 0)
					growing = 1'b0;
				else if (!growing && shadow.fill == 0)
					growing = 1'b1;
				else if ($urandom_range(49) == 0)
					growing = !growing;
				op = pick_op(growing);
				send_op(op, pick_value(op));
				if (op <= OP_CLEAR)
					issued++;
			end
			if ($urandom_range(3) != 0)
				idle_sender($urandom_range(1, 7));
		end
		s_tvalid <= 1'b0;

		// Drain and settle
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (shadow.fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: check each transfer, stall on its own pattern, one long hold-off
	initial begin : receiver
		int unsigned hold_left;
		int unsigned mode;
		int unsigned mode_left;
		int unsigned phase;
		bit          held;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		phase = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				shadow.check_report(m_tdata);
			if (!held && shadow.checked_count >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			phase++;
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(1) == 0);
					2: m_tready <= ($urandom_range(6) != 0);
					default: m_tready <= (phase % 3 == 0);
				endcase
			end
		end
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ordered_list_engine_top.sv
rtl/ole_checker.sv
bench/testbench.sv
